// ===== rtl/softbody_tail_verlet_step_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Softbody tail step assertion macros
// Shared assertion forms for the tail step unit, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SOFTBODY_TAIL_VERLET_STEP_UNIT_ASSERT_SVH
`define SOFTBODY_TAIL_VERLET_STEP_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sbtail_pkg.sv =====
// ----------------------------------------------------------------------------
// Softbody tail step package
// Field and port widths, datapath widths, register indexes, axis selectors and saturation helper.
// ----------------------------------------------------------------------------
package sbtail_pkg;

  // Field widths
  localparam int POS_W     = 32;
  localparam int AX_W      = 19;
  localparam int COEF_W    = 17;
  localparam int LEN_W     = 31;
  localparam int COEF_FRAC = 16;
  localparam int FRAC_BITS_DEF = 16;

  // Stream and configuration port widths
  localparam int IN_DATA_W  = 256;
  localparam int OUT_DATA_W = 3 * POS_W;
  localparam int IN_AX_LSB  = 6 * POS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ELAST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGID    = 3'd5;

  localparam logic [LEN_W-1:0] REST_LEN_RST = 31'd65536;

  // Serial datapath widths
  localparam int ACC_W    = 72;  // product accumulator and shift source
  localparam int MR_W     = 34;  // multiplier operand, one bit per cycle
  localparam int SQ_IN_W  = 70;  // square root radicand, two bits per cycle
  localparam int SQ_STEPS = SQ_IN_W / 2;
  localparam int ROOT_W   = 35;
  localparam int REM_W    = 40;
  localparam int DIV_IN_W = 65;  // dividend, one bit per cycle
  localparam int Q_W      = 33;
  localparam int CNT_W    = 7;
  localparam int VS_W     = 42;
  localparam int DF_W     = 36;
  localparam int RD_W     = 48;
  localparam int SAT_W    = 48;

  // Axis selectors
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  // Clamp a wide signed value into the 32-bit position range.
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(32'sh7FFF_FFFF);
    lo = -hi - SAT_W'(1);
    if (v > hi) begin
      return POS_W'(hi);
    end else if (v < lo) begin
      return POS_W'(lo);
    end
    return POS_W'(v);
  endfunction

endpackage

// ===== rtl/softbody_tail_verlet_step_unit.sv =====
// The sequence skips the length correction when the tail lands on the head.
// A new input is accepted only once the previous result is in the output
// register; the 34-step shift-add multiplier (21 uses), the 35-step square
// root and the 65-step divider make up most of each item's sequence.
// Reset clears the tail, previous tail and previous head to zero and loads
// the register defaults (rest length one, all other registers zero).
// ----------------------------------------------------------------------------
// Softbody tail Verlet step unit
// Verlet step with drag, friction and gravity, then a length correction
// toward the rest length and a pull toward the rest pose, all computed by
// bit-serial multiply, square root and divide units under one sequencer.
// ----------------------------------------------------------------------------
`include "softbody_tail_verlet_step_unit_assert.svh"

module softbody_tail_verlet_step_unit #(
  parameter int FRAC_BITS = sbtail_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // head_x, head_y, head_z, origin_x, origin_y, origin_z, axis_x, axis_y, axis_z
  input  logic [sbtail_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // Result stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tail_x, tail_y, tail_z
  output logic [sbtail_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // Configuration writes
  input  logic                                cfg_we_i,
  input  logic [sbtail_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sbtail_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sbtail_pkg::*;

  // Sequencer states
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_V_ABS  = 5'd1;
  localparam logic [4:0] ST_V_LOC  = 5'd2;
  localparam logic [4:0] ST_V_END  = 5'd3;
  localparam logic [4:0] ST_L_SQ   = 5'd4;
  localparam logic [4:0] ST_L_SQE  = 5'd5;
  localparam logic [4:0] ST_SQRT   = 5'd6;
  localparam logic [4:0] ST_L_CHK  = 5'd7;
  localparam logic [4:0] ST_L_NUM  = 5'd8;
  localparam logic [4:0] ST_L_DIVS = 5'd9;
  localparam logic [4:0] ST_DIV    = 5'd10;
  localparam logic [4:0] ST_L_DIFF = 5'd11;
  localparam logic [4:0] ST_L_END  = 5'd12;
  localparam logic [4:0] ST_R_AX   = 5'd13;
  localparam logic [4:0] ST_R_DIFF = 5'd14;
  localparam logic [4:0] ST_R_END  = 5'd15;
  localparam logic [4:0] ST_OUT    = 5'd16;
  localparam logic [4:0] ST_MUL    = 5'd17;

  localparam logic signed [ACC_W-1:0] RND_COEF = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] RND_FRAC = ACC_W'(1) <<< (FRAC_BITS - 1);

  // Control state
  logic [4:0]             state_q, state_d, ret_q, ret_d;
  logic [1:0]             idx_q, idx_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   ovalid_q, ovalid_d;

  // Configuration registers
  logic [COEF_W-1:0]      drag_q, fric_q, elast_q, rigid_q;
  logic [LEN_W-1:0]       grav_q, rlen_q;

  // Kept positions
  logic signed [POS_W-1:0] tail_q [3], tail_d [3];
  logic signed [POS_W-1:0] ptail_q [3], ptail_d [3];
  logic signed [POS_W-1:0] phead_q [3], phead_d [3];

  // Item payload and working tail
  logic signed [POS_W-1:0] head_q [3], head_d [3];
  logic signed [POS_W-1:0] org_q [3], org_d [3];
  logic signed [AX_W-1:0]  ax_q [3], ax_d [3];
  logic signed [POS_W-1:0] t_q [3], t_d [3];

  // Serial units
  logic signed [ACC_W-1:0] mc_q, mc_d, acc_q, acc_d;
  logic signed [MR_W-1:0]  mr_q, mr_d;
  logic [REM_W-1:0]        rem_q, rem_d;
  logic [ROOT_W-1:0]       root_q, root_d;
  logic [Q_W-1:0]          q_q, q_d;
  logic [OUT_DATA_W-1:0]   odata_q, odata_d;

  // Per-axis operands
  logic signed [POS_W-1:0] head_c, org_c, tail_c, ptail_c, phead_c, t_c;
  logic signed [AX_W-1:0]  ax_c;
  logic signed [POS_W:0]   absv_c, e_c;
  logic signed [POS_W+2:0] locv_c;
  logic [POS_W:0]          emag_c;
  logic signed [COEF_W:0]  kd_c, kf_c;
  logic signed [VS_W-1:0]  grav_c, vsum_c, lsum_c;
  logic signed [DF_W-1:0]  qs_c, es_c, ldiff_c;
  logic signed [RD_W-1:0]  rdiff_c;
  logic [REM_W-1:0]        sq_sh_c, sq_trial_c, div_sh_c, div_den_c;

  assign head_c  = head_q[idx_q];
  assign org_c   = org_q[idx_q];
  assign ax_c    = ax_q[idx_q];
  assign tail_c  = tail_q[idx_q];
  assign ptail_c = ptail_q[idx_q];
  assign phead_c = phead_q[idx_q];
  assign t_c     = t_q[idx_q];

  // Verlet terms: absolute velocity, local velocity and blend factors
  assign absv_c = (POS_W+1)'(head_c) - (POS_W+1)'(phead_c);
  assign locv_c = ((POS_W+3)'(tail_c) - (POS_W+3)'(ptail_c)) - (POS_W+3)'(absv_c);
  assign kd_c   = (COEF_W+1)'(1 << COEF_FRAC) - $signed({1'b0, drag_q});
  assign kf_c   = (COEF_W+1)'(1 << COEF_FRAC) - $signed({1'b0, fric_q});
  assign grav_c = (idx_q == AXIS_Y) ? $signed(VS_W'(grav_q)) : '0;
  assign vsum_c = VS_W'(tail_c) + VS_W'(acc_q >>> COEF_FRAC) - grav_c;

  // Offset from head and its magnitude
  assign e_c    = (POS_W+1)'(t_c) - (POS_W+1)'(head_c);
  assign emag_c = e_c[POS_W] ? (POS_W+1)'(-e_c) : (POS_W+1)'(e_c);

  // Length correction: ideal minus tail is +q - e, or -q - e for a negative offset
  assign qs_c    = $signed(DF_W'(q_q));
  assign es_c    = DF_W'(e_c);
  assign ldiff_c = e_c[POS_W] ? -(qs_c + es_c) : (qs_c - es_c);
  assign lsum_c  = VS_W'(t_c) + VS_W'(acc_q >>> COEF_FRAC);

  // Rest pose correction operand
  assign rdiff_c = RD_W'(org_c) + RD_W'(acc_q >>> FRAC_BITS) - RD_W'(t_c);

  // Square root and divider steps
  assign sq_sh_c    = {rem_q[REM_W-3:0], acc_q[ACC_W-1 -: 2]};
  assign sq_trial_c = REM_W'({root_q, 2'b01});
  assign div_sh_c   = {rem_q[REM_W-2:0], acc_q[ACC_W-1]};
  assign div_den_c  = REM_W'(root_q);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

  // Sequencer and datapath next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    tail_d  = tail_q;
    ptail_d = ptail_q;
    phead_d = phead_q;
    head_d  = head_q;
    org_d   = org_q;
    ax_d    = ax_q;
    t_d     = t_q;
    mc_d    = mc_q;
    mr_d    = mr_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    root_d  = root_q;
    q_d     = q_q;
    odata_d = odata_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          for (int k = 0; k < 3; k++) begin
            head_d[k] = s_axis_tdata_i[k*POS_W +: POS_W];
            org_d[k]  = s_axis_tdata_i[(k+3)*POS_W +: POS_W];
            ax_d[k]   = s_axis_tdata_i[IN_AX_LSB + k*AX_W +: AX_W];
          end
          idx_d   = AXIS_X;
          state_d = ST_V_ABS;
        end
      end
      // Absolute velocity times (one - drag), rounding bias preloaded
      ST_V_ABS: begin
        mc_d    = ACC_W'(absv_c);
        mr_d    = MR_W'(kd_c);
        acc_d   = RND_COEF;
        cnt_d   = '0;
        ret_d   = ST_V_LOC;
        state_d = ST_MUL;
      end
      // Local velocity times (one - friction), summed onto the same accumulator
      ST_V_LOC: begin
        mc_d    = ACC_W'(locv_c);
        mr_d    = MR_W'(kf_c);
        cnt_d   = '0;
        ret_d   = ST_V_END;
        state_d = ST_MUL;
      end
      ST_V_END: begin
        t_d[idx_q]     = sat32(SAT_W'(vsum_c));
        phead_d[idx_q] = head_c;
        ptail_d[idx_q] = tail_c;
        if (idx_q == AXIS_LAST) begin
          idx_d   = AXIS_X;
          acc_d   = '0;
          state_d = ST_L_SQ;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_V_ABS;
        end
      end
      // Sum of squared offsets
      ST_L_SQ: begin
        mc_d    = $signed(ACC_W'(emag_c));
        mr_d    = $signed(MR_W'(emag_c));
        cnt_d   = '0;
        ret_d   = ST_L_SQE;
        state_d = ST_MUL;
      end
      ST_L_SQE: begin
        if (idx_q == AXIS_LAST) begin
          idx_d   = AXIS_X;
          acc_d   = acc_q <<< (ACC_W - SQ_IN_W);
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = ST_SQRT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_L_SQ;
        end
      end
      // Floor square root, two radicand bits per cycle
      ST_SQRT: begin
        if (sq_sh_c >= sq_trial_c) begin
          rem_d  = sq_sh_c - sq_trial_c;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = sq_sh_c;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        acc_d = acc_q <<< 2;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SQ_STEPS - 1)) begin
          state_d = ST_L_CHK;
        end
      end
      // Zero distance skips the length correction
      ST_L_CHK: begin
        idx_d   = AXIS_X;
        state_d = (root_q == '0) ? ST_R_AX : ST_L_NUM;
      end
      // Offset magnitude times rest length, plus half the distance for rounding
      ST_L_NUM: begin
        mc_d    = $signed(ACC_W'(emag_c));
        mr_d    = $signed(MR_W'(rlen_q));
        acc_d   = $signed(ACC_W'(root_q >> 1));
        cnt_d   = '0;
        ret_d   = ST_L_DIVS;
        state_d = ST_MUL;
      end
      ST_L_DIVS: begin
        acc_d   = acc_q <<< (ACC_W - DIV_IN_W);
        rem_d   = '0;
        q_d     = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      // Restoring division by the distance, one quotient bit per cycle
      ST_DIV: begin
        if (div_sh_c >= div_den_c) begin
          rem_d = div_sh_c - div_den_c;
          q_d   = {q_q[Q_W-2:0], 1'b1};
        end else begin
          rem_d = div_sh_c;
          q_d   = {q_q[Q_W-2:0], 1'b0};
        end
        acc_d = acc_q <<< 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_IN_W - 1)) begin
          state_d = ST_L_DIFF;
        end
      end
      ST_L_DIFF: begin
        mc_d    = ACC_W'(ldiff_c);
        mr_d    = $signed(MR_W'(elast_q));
        acc_d   = RND_COEF;
        cnt_d   = '0;
        ret_d   = ST_L_END;
        state_d = ST_MUL;
      end
      ST_L_END: begin
        t_d[idx_q] = sat32(SAT_W'(lsum_c));
        if (idx_q == AXIS_LAST) begin
          idx_d   = AXIS_X;
          state_d = ST_R_AX;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_L_NUM;
        end
      end
      // Rest pose target: origin plus axis times rest length
      ST_R_AX: begin
        mc_d    = ACC_W'(ax_c);
        mr_d    = $signed(MR_W'(rlen_q));
        acc_d   = RND_FRAC;
        cnt_d   = '0;
        ret_d   = ST_R_DIFF;
        state_d = ST_MUL;
      end
      ST_R_DIFF: begin
        mc_d    = ACC_W'(rdiff_c);
        mr_d    = $signed(MR_W'(rigid_q));
        acc_d   = RND_COEF;
        cnt_d   = '0;
        ret_d   = ST_R_END;
        state_d = ST_MUL;
      end
      ST_R_END: begin
        t_d[idx_q]    = sat32(SAT_W'(lsum_c));
        tail_d[idx_q] = sat32(SAT_W'(lsum_c));
        if (idx_q == AXIS_LAST) begin
          state_d = ST_OUT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_R_AX;
        end
      end
      // Hand the result to the output register once it is free
      ST_OUT: begin
        if (!ovalid_q || m_axis_tready_i) begin
          odata_d  = {tail_q[2], tail_q[1], tail_q[0]};
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      // Shift-add multiply, LSB first; the sign bit carries negative weight
      ST_MUL: begin
        if (mr_q[0]) begin
          if (cnt_q == CNT_W'(MR_W - 1)) begin
            acc_d = acc_q - mc_q;
          end else begin
            acc_d = acc_q + mc_q;
          end
        end
        mc_d  = mc_q <<< 1;
        mr_d  = mr_q >>> 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MR_W - 1)) begin
          state_d = ret_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers, kept positions and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_IDLE;
      idx_q    <= AXIS_X;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      drag_q   <= '0;
      fric_q   <= '0;
      grav_q   <= '0;
      rlen_q   <= REST_LEN_RST;
      elast_q  <= '0;
      rigid_q  <= '0;
      for (int k = 0; k < 3; k++) begin
        tail_q[k]  <= '0;
        ptail_q[k] <= '0;
        phead_q[k] <= '0;
      end
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      tail_q   <= tail_d;
      ptail_q  <= ptail_d;
      phead_q  <= phead_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DRAG:     drag_q  <= cfg_data_i[COEF_W-1:0];
          CFG_FRICTION: fric_q  <= cfg_data_i[COEF_W-1:0];
          CFG_GRAVITY:  grav_q  <= cfg_data_i[LEN_W-1:0];
          CFG_REST_LEN: rlen_q  <= cfg_data_i[LEN_W-1:0];
          CFG_ELAST:    elast_q <= cfg_data_i[COEF_W-1:0];
          CFG_RIGID:    rigid_q <= cfg_data_i[COEF_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload and serial unit registers
  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    org_q   <= org_d;
    ax_q    <= ax_d;
    t_q     <= t_d;
    mc_q    <= mc_d;
    mr_q    <= mr_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    q_q     <= q_d;
    odata_q <= odata_d;
  end

  // Checks on the sequencer and serial units
  `SBT_ASSERT_NEXT(a_accept_starts, s_axis_tvalid_i && s_axis_tready_o, state_q != ST_IDLE, "input transfer did not start the sequence")
  `SBT_ASSERT_NOW(a_mul_count, state_q == ST_MUL, cnt_q < CNT_W'(MR_W), "multiplier ran past its last bit")
  `SBT_ASSERT_NOW(a_div_rem, state_q == ST_DIV, rem_q < div_den_c, "divider remainder not below the distance")
  `SBT_ASSERT_NOW(a_num_nonzero, state_q == ST_L_NUM, root_q != '0, "length correction entered with zero distance")
  `SBT_ASSERT_NOW(a_result_src, $rose(m_axis_tvalid_o), $past(state_q) == ST_OUT, "result appeared outside the output step")

endmodule
